// ===== hdl/bqdf1_pkg.sv =====
// Shared constants, types and register codes for the direct form I biquad filter.
package bqdf1_pkg;

    localparam int CHANNELS    = 8;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;
    localparam int CHAN_BITS   = 3;
    localparam int NUM_REGS    = 5;
    localparam int IDX_BITS    = 3;

    localparam int ADDR_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS   = PROD_BITS + 3;
    localparam int FRAC_SHIFT = COEF_BITS - 2;
    localparam int STEP_BITS  = $clog2(NUM_REGS + 1);

    // coefficient register indexes, also the order of the multiply passes
    typedef enum logic [IDX_BITS-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } reg_idx_t;

    // one channel's delay line, kept as a single memory word
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x1;
        logic signed [SAMPLE_BITS-1:0] x2;
        logic signed [SAMPLE_BITS-1:0] y1;
        logic signed [SAMPLE_BITS-1:0] y2;
    } dline_t;

    localparam int ENTRY_BITS = 4 * SAMPLE_BITS;

endpackage

// ===== hdl/bqdf1_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module bqdf1_ram #(
    parameter  int WIDTH     = 32,
    parameter  int DEPTH     = 8,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold the last read word until the next read
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/biquad_direct_form_one_filter_top.sv =====
// Multi-channel direct form I biquad filter: top level with shared multiply-accumulate engine.
// Each transaction goes through the delay-line read, five multiply passes plus a drain, and the
//   write-back; the next starts only once the engine is idle. A result waits in the output
//   register while the engine takes the next transaction from the input holding register.
// Reset: coefficients clear to zero; per-channel valid flags make each delay line read as zero.
module biquad_direct_form_one_filter_top (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // configuration write port
    input  logic                                      cfg_wr_en,
    input  logic [bqdf1_pkg::IDX_BITS-1:0]            cfg_index,
    input  logic [bqdf1_pkg::COEF_BITS-1:0]           cfg_data,
    // input channel
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic [bqdf1_pkg::CHAN_BITS-1:0]           chan,
    input  logic signed [bqdf1_pkg::SAMPLE_BITS-1:0]  sample_in,
    // output channel
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [bqdf1_pkg::CHAN_BITS-1:0]           chan_out,
    output logic signed [bqdf1_pkg::SAMPLE_BITS-1:0]  sample_out,
    output logic                                      clipped
);

    localparam int SB = bqdf1_pkg::SAMPLE_BITS;
    localparam int CB = bqdf1_pkg::COEF_BITS;
    localparam int AB = bqdf1_pkg::ACC_BITS;

    // every 3-bit channel code is in range when the block has at least that many channels
    localparam bit ALL_CHAN = bqdf1_pkg::CHANNELS >= (1 << bqdf1_pkg::CHAN_BITS);

    // half an output LSB in the accumulator's fixed-point format
    localparam logic signed [AB-1:0] ROUND_HALF = AB'(1) << (CB - 3);

    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [AB-1:0] Y_MAX      = AB'(SAMPLE_MAX);
    localparam logic signed [AB-1:0] Y_MIN      = AB'(SAMPLE_MIN);

    localparam logic [bqdf1_pkg::STEP_BITS-1:0] STEP_LAST =
        bqdf1_pkg::STEP_BITS'(bqdf1_pkg::NUM_REGS);

    // engine sequence: issue the RAM read, five multiply passes plus a drain, then finish
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FIN
    } state_t;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    state_t                               state_reg, state_next;
    logic [bqdf1_pkg::STEP_BITS-1:0]      step_reg, step_next;
    logic                                 buf_valid_reg, buf_valid_next;
    logic                                 out_valid_reg, out_valid_next;
    logic                                 chan_vld_reg [bqdf1_pkg::CHANNELS];
    logic signed [CB-1:0]                 coef_reg [bqdf1_pkg::NUM_REGS];

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic [bqdf1_pkg::CHAN_BITS-1:0]      buf_chan_reg;
    logic signed [SB-1:0]                 buf_sample_reg;
    logic [bqdf1_pkg::CHAN_BITS-1:0]      wk_chan_reg;
    logic signed [SB-1:0]                 wk_sample_reg;
    logic                                 wk_ok_reg;
    logic                                 ent_vld_reg;
    logic signed [bqdf1_pkg::PROD_BITS-1:0] prod_reg, prod_next;
    logic                                 prod_sub_reg, prod_sub_next;
    logic signed [AB-1:0]                 acc_reg, acc_next;
    logic [bqdf1_pkg::CHAN_BITS-1:0]      chan_out_reg;
    logic signed [SB-1:0]                 sample_out_reg, sample_out_next;
    logic                                 clipped_reg, clipped_next;

    // ------------------------------------------------------------------
    // Handshake and sequencing
    // ------------------------------------------------------------------
    logic take;
    logic in_fire;
    logic fin_go;
    logic buf_ok;

    logic [bqdf1_pkg::ADDR_BITS-1:0] rd_addr;
    logic [bqdf1_pkg::ADDR_BITS-1:0] wr_addr;
    logic                            ram_wr_en;
    logic [bqdf1_pkg::ENTRY_BITS-1:0] ram_rd_data;
    bqdf1_pkg::dline_t               ent_raw;
    bqdf1_pkg::dline_t               ent_new;

    logic signed [SB-1:0] old_x1, old_x2, old_y1, old_y2;
    logic signed [CB-1:0] mul_coef;
    logic signed [SB-1:0] mul_data;
    logic signed [AB-1:0] rnd_sum;
    logic signed [AB-1:0] y_wide;

    // the engine takes the held transaction whenever it is free
    assign take     = (state_reg == ST_IDLE) && buf_valid_reg;
    assign in_stall = buf_valid_reg && !take;
    assign in_fire  = in_valid && !in_stall;
    assign fin_go   = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);
    assign buf_ok   = ALL_CHAN || (int'(buf_chan_reg) < bqdf1_pkg::CHANNELS);

    assign rd_addr  = bqdf1_pkg::ADDR_BITS'(buf_chan_reg);
    assign wr_addr  = bqdf1_pkg::ADDR_BITS'(wk_chan_reg);

    // ------------------------------------------------------------------
    // Delay-line state RAM: one word per channel
    // ------------------------------------------------------------------
    bqdf1_ram #(
        .WIDTH (bqdf1_pkg::ENTRY_BITS),
        .DEPTH (bqdf1_pkg::CHANNELS)
    ) u_dline_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_addr),
        .wr_data (ent_new),
        .rd_en   (take),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // a channel never written reads as zero
    assign ent_raw = bqdf1_pkg::dline_t'(ram_rd_data);
    assign old_x1  = ent_vld_reg ? ent_raw.x1 : '0;
    assign old_x2  = ent_vld_reg ? ent_raw.x2 : '0;
    assign old_y1  = ent_vld_reg ? ent_raw.y1 : '0;
    assign old_y2  = ent_vld_reg ? ent_raw.y2 : '0;

    // ------------------------------------------------------------------
    // Shared multiplier: one tap per pass, taps in register order
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_coef      = '0;
        mul_data      = '0;
        prod_sub_next = 1'b0;
        case (step_reg)
            bqdf1_pkg::REG_B0:
            begin
                mul_coef = coef_reg[bqdf1_pkg::REG_B0];
                mul_data = wk_sample_reg;
            end
            bqdf1_pkg::REG_B1:
            begin
                mul_coef = coef_reg[bqdf1_pkg::REG_B1];
                mul_data = old_x1;
            end
            bqdf1_pkg::REG_B2:
            begin
                mul_coef = coef_reg[bqdf1_pkg::REG_B2];
                mul_data = old_x2;
            end
            bqdf1_pkg::REG_A1:
            begin
                mul_coef      = coef_reg[bqdf1_pkg::REG_A1];
                mul_data      = old_y1;
                prod_sub_next = 1'b1;
            end
            bqdf1_pkg::REG_A2:
            begin
                mul_coef      = coef_reg[bqdf1_pkg::REG_A2];
                mul_data      = old_y2;
                prod_sub_next = 1'b1;
            end
            default:
            begin
                mul_coef      = '0;
                mul_data      = '0;
                prod_sub_next = 1'b0;
            end
        endcase
        prod_next = mul_coef * mul_data;
    end

    // accumulate the previous pass's product; clear on the first pass
    always_comb
    begin
        if (step_reg == '0)
        begin
            acc_next = '0;
        end
        else if (prod_sub_reg)
        begin
            acc_next = acc_reg - AB'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + AB'(prod_reg);
        end
    end

    // ------------------------------------------------------------------
    // Round half up, drop the fraction, saturate to the sample range; an out-of-range channel gives zero
    // ------------------------------------------------------------------
    assign rnd_sum = acc_reg + ROUND_HALF;
    assign y_wide  = rnd_sum >>> bqdf1_pkg::FRAC_SHIFT;

    always_comb
    begin
        if (!wk_ok_reg)
        begin
            sample_out_next = '0;
            clipped_next    = 1'b0;
        end
        else if (y_wide > Y_MAX)
        begin
            sample_out_next = SAMPLE_MAX;
            clipped_next    = 1'b1;
        end
        else if (y_wide < Y_MIN)
        begin
            sample_out_next = SAMPLE_MIN;
            clipped_next    = 1'b1;
        end
        else
        begin
            sample_out_next = SB'(y_wide);
            clipped_next    = 1'b0;
        end
    end

    // shift the channel's delay line with the saturated output
    assign ent_new.x1 = wk_sample_reg;
    assign ent_new.x2 = old_x1;
    assign ent_new.y1 = sample_out_next;
    assign ent_new.y2 = old_y1;
    assign ram_wr_en  = fin_go && wk_ok_reg;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        buf_valid_next = buf_valid_reg;
        out_valid_next = out_valid_reg;

        if (in_fire)
        begin
            buf_valid_next = 1'b1;
        end
        else if (take)
        begin
            buf_valid_next = 1'b0;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_MAC;
                    step_next  = '0;
                end
            end
            ST_MAC:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control state, registered output valid and coefficients
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < bqdf1_pkg::CHANNELS; i++)
            begin
                chan_vld_reg[i] <= 1'b0;
            end
            for (int i = 0; i < bqdf1_pkg::NUM_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
            if (ram_wr_en)
            begin
                chan_vld_reg[wr_addr] <= 1'b1;
            end
            if (cfg_wr_en)
            begin
                unique case (bqdf1_pkg::reg_idx_t'(cfg_index))
                    bqdf1_pkg::REG_B0: coef_reg[bqdf1_pkg::REG_B0] <= cfg_data;
                    bqdf1_pkg::REG_B1: coef_reg[bqdf1_pkg::REG_B1] <= cfg_data;
                    bqdf1_pkg::REG_B2: coef_reg[bqdf1_pkg::REG_B2] <= cfg_data;
                    bqdf1_pkg::REG_A1: coef_reg[bqdf1_pkg::REG_A1] <= cfg_data;
                    bqdf1_pkg::REG_A2: coef_reg[bqdf1_pkg::REG_A2] <= cfg_data;
                    default:
                    begin
                        // drop writes beyond the last register
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            buf_chan_reg   <= chan;
            buf_sample_reg <= sample_in;
        end
        if (take)
        begin
            wk_chan_reg   <= buf_chan_reg;
            wk_sample_reg <= buf_sample_reg;
            wk_ok_reg     <= buf_ok;
            ent_vld_reg   <= buf_ok && chan_vld_reg[rd_addr];
        end
        if (state_reg == ST_MAC)
        begin
            prod_reg     <= prod_next;
            prod_sub_reg <= prod_sub_next;
            acc_reg      <= acc_next;
        end
        if (fin_go)
        begin
            chan_out_reg   <= wk_chan_reg;
            sample_out_reg <= sample_out_next;
            clipped_reg    <= clipped_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign chan_out   = chan_out_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

endmodule

// ===== sim/biquad_response_checker.sv =====
// Checker for the direct form I biquad: predicts each filtered sample and compares it on output.
`timescale 1ns / 1ps

module biquad_response_checker (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_wr_en,
    input  logic [bqdf1_pkg::IDX_BITS-1:0]           cfg_index,
    input  logic [bqdf1_pkg::COEF_BITS-1:0]          cfg_data,
    input  logic                                     in_valid,
    input  logic                                     in_stall,
    input  logic [bqdf1_pkg::CHAN_BITS-1:0]          chan,
    input  logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                     out_valid,
    input  logic                                     out_stall,
    input  logic [bqdf1_pkg::CHAN_BITS-1:0]          chan_out,
    input  logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] sample_out,
    input  logic                                     clipped,
    output int                                       errors,
    output int                                       outstanding
);

    typedef struct {
        logic [bqdf1_pkg::CHAN_BITS-1:0]          ch;
        logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] y;
        logic                                     clip;
    } filtered_t;

    filtered_t                                filtered_due[$];
    logic signed [bqdf1_pkg::COEF_BITS-1:0]   taps [bqdf1_pkg::NUM_REGS];
    logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] x1_mem [bqdf1_pkg::CHANNELS];
    logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] x2_mem [bqdf1_pkg::CHANNELS];
    logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] y1_mem [bqdf1_pkg::CHANNELS];
    logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] y2_mem [bqdf1_pkg::CHANNELS];
    int                                       error_tally = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        begin
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            error_tally++;
        end
    endtask

    // exact five-tap sum, round half up, saturate, then advance the channel's delay line
    function automatic filtered_t filter_sample(
        input logic [bqdf1_pkg::CHAN_BITS-1:0]          ch,
        input logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] x);
        filtered_t r;
        longint    acc;
        longint    ymax;
        longint    ymin;
        ymax   = (longint'(1) << (bqdf1_pkg::SAMPLE_BITS - 1)) - 1;
        ymin   = -(longint'(1) << (bqdf1_pkg::SAMPLE_BITS - 1));
        r.ch   = ch;
        r.y    = '0;
        r.clip = 1'b0;
        if (ch >= bqdf1_pkg::CHANNELS)
            return r;
        acc = longint'(taps[bqdf1_pkg::REG_B0]) * longint'(x)
            + longint'(taps[bqdf1_pkg::REG_B1]) * longint'(x1_mem[ch])
            + longint'(taps[bqdf1_pkg::REG_B2]) * longint'(x2_mem[ch])
            - longint'(taps[bqdf1_pkg::REG_A1]) * longint'(y1_mem[ch])
            - longint'(taps[bqdf1_pkg::REG_A2]) * longint'(y2_mem[ch]);
        acc = (acc + (longint'(1) << (bqdf1_pkg::FRAC_SHIFT - 1))) >>> bqdf1_pkg::FRAC_SHIFT;
        if (acc > ymax)
        begin
            acc    = ymax;
            r.clip = 1'b1;
        end
        else if (acc < ymin)
        begin
            acc    = ymin;
            r.clip = 1'b1;
        end
        r.y        = acc[bqdf1_pkg::SAMPLE_BITS-1:0];
        x2_mem[ch] = x1_mem[ch];
        x1_mem[ch] = x;
        y2_mem[ch] = y1_mem[ch];
        y1_mem[ch] = r.y;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        filtered_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < bqdf1_pkg::NUM_REGS; i++)
                taps[i] = '0;
            for (int i = 0; i < bqdf1_pkg::CHANNELS; i++)
            begin
                x1_mem[i] = '0;
                x2_mem[i] = '0;
                y1_mem[i] = '0;
                y2_mem[i] = '0;
            end
            filtered_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en && cfg_index < bqdf1_pkg::NUM_REGS)
                taps[cfg_index] = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (filtered_due.size() == 0)
                begin
                    report_mismatch("result with none due, channel", chan_out, -1);
                end
                else
                begin
                    want = filtered_due.pop_front();
                    if (chan_out !== want.ch)
                        report_mismatch("chan_out", chan_out, want.ch);
                    if (sample_out !== want.y)
                        report_mismatch("sample_out", sample_out, want.y);
                    if (clipped !== want.clip)
                        report_mismatch("clipped", clipped, want.clip);
                end
            end
            if (in_valid && !in_stall)
                filtered_due.push_back(filter_sample(chan, sample_in));
            outstanding <= filtered_due.size();
            errors      <= error_tally;
        end
    end

endmodule

// ===== sim/biquad_direct_form_one_filter_top_tb.sv =====
// Top-level testbench for the direct form I biquad: stimulus, coefficient phases and verdict.
`timescale 1ns / 1ps

module biquad_direct_form_one_filter_top_tb;

    // most and least coefficient values in Q2.22, and unity gain
    localparam logic signed [bqdf1_pkg::COEF_BITS-1:0]   COEF_MAX   =
        {1'b0, {(bqdf1_pkg::COEF_BITS-1){1'b1}}};
    localparam logic signed [bqdf1_pkg::COEF_BITS-1:0]   COEF_MIN   =
        {1'b1, {(bqdf1_pkg::COEF_BITS-1){1'b0}}};
    localparam logic signed [bqdf1_pkg::COEF_BITS-1:0]   COEF_UNITY =
        bqdf1_pkg::COEF_BITS'(1 << bqdf1_pkg::FRAC_SHIFT);
    localparam logic signed [bqdf1_pkg::COEF_BITS-1:0]   COEF_LSB   =
        bqdf1_pkg::COEF_BITS'(1);
    localparam logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] SAMP_MAX   =
        {1'b0, {(bqdf1_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] SAMP_MIN   =
        {1'b1, {(bqdf1_pkg::SAMPLE_BITS-1){1'b0}}};
    // half an output LSB when b0 is one coefficient LSB
    localparam logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] SAMP_HALF  =
        bqdf1_pkg::SAMPLE_BITS'(1 << (bqdf1_pkg::FRAC_SHIFT - 1));
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 80;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 2000;

    logic                                     clk = 1'b0;
    logic                                     rst_n;
    logic                                     cfg_wr_en;
    logic [bqdf1_pkg::IDX_BITS-1:0]           cfg_index;
    logic [bqdf1_pkg::COEF_BITS-1:0]          cfg_data;
    logic                                     in_valid;
    logic                                     in_stall;
    logic [bqdf1_pkg::CHAN_BITS-1:0]          chan;
    logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] sample_in;
    logic                                     out_valid;
    logic                                     out_stall;
    logic [bqdf1_pkg::CHAN_BITS-1:0]          chan_out;
    logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] sample_out;
    logic                                     clipped;

    int   errors;
    int   outstanding;
    int   quiet_cycles = 0;
    int   stall_left   = 0;
    bit   calm         = 1'b0;   // set for the closing stretch: no idling on either side
    logic [bqdf1_pkg::CHAN_BITS-1:0] last_chan = '0;

    biquad_direct_form_one_filter_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .chan       (chan),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .chan_out   (chan_out),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

    biquad_response_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .chan        (chan),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .chan_out    (chan_out),
        .sample_out  (sample_out),
        .clipped     (clipped),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: count cycles with no transaction on either channel and give up at the limit.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("biquad_direct_form_one_filter_top_tb: FAIL");
            $finish;
        end
    end

    // Receiver back-pressure: random stall bursts, none begun once calm.
    // Exactly one assignment to out_stall per edge, so a burst never glitches.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 8) - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Present one sample, hold it until the transaction is taken, then maybe leave a gap.
    // The next call may raise valid again in the same step, so valid is only lowered for a gap.
    task automatic send_sample(input logic [bqdf1_pkg::CHAN_BITS-1:0] c,
                               input logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] s);
        begin
            in_valid  <= 1'b1;
            chan      <= c;
            sample_in <= s;
            do
                @(posedge clk);
            while (in_stall);
            last_chan = c;
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    // Stop sending and hold off until every expected result has come back, then let the
    // engine settle before anything touches the coefficients.
    task automatic drain_filter();
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (outstanding != 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [bqdf1_pkg::IDX_BITS-1:0] idx,
                             input logic [bqdf1_pkg::COEF_BITS-1:0] val);
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
        end
    endtask

    task automatic load_coefs(input logic signed [bqdf1_pkg::COEF_BITS-1:0] b0, b1, b2, a1, a2);
        begin
            write_reg(bqdf1_pkg::REG_B0, b0);
            write_reg(bqdf1_pkg::REG_B1, b1);
            write_reg(bqdf1_pkg::REG_B2, b2);
            write_reg(bqdf1_pkg::REG_A1, a1);
            write_reg(bqdf1_pkg::REG_A2, a2);
            cfg_wr_en <= 1'b0;
        end
    endtask

    // Bias towards the rails and small values, which is where rounding and clipping live.
    function automatic logic signed [bqdf1_pkg::SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMP_MAX;
            1:       return SAMP_MIN;
            2:       return bqdf1_pkg::SAMPLE_BITS'($urandom_range(0, 4095))
                            - bqdf1_pkg::SAMPLE_BITS'(2048);
            default: return bqdf1_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic signed [bqdf1_pkg::COEF_BITS-1:0] pick_rail_coef();
        case ($urandom_range(0, 2))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            default: return '0;
        endcase
    endfunction

    // Mostly stay on the same channel so each delay line sees runs of samples.
    function automatic logic [bqdf1_pkg::CHAN_BITS-1:0] pick_chan();
        if ($urandom_range(0, 1) == 0)
            return last_chan;
        return bqdf1_pkg::CHAN_BITS'($urandom_range(0, bqdf1_pkg::CHANNELS - 1));
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        chan      = '0;
        sample_in = '0;
        out_stall = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Coefficients straight out of reset are all zero: output must be silent.
        send_sample(3'd0, SAMP_MAX);
        send_sample(3'd7, SAMP_MIN);
        drain_filter();

        // Junk written to the spare indexes first must change nothing. Then b0 one LSB: the first
        // two sums land exactly on half an LSB, so rounding goes towards plus infinity.
        for (int i = bqdf1_pkg::NUM_REGS; i < (1 << bqdf1_pkg::IDX_BITS); i++)
            write_reg(bqdf1_pkg::IDX_BITS'(i), '1);
        load_coefs(COEF_LSB, '0, '0, '0, '0);
        send_sample(3'd1, SAMP_HALF);
        send_sample(3'd1, -SAMP_HALF);
        send_sample(3'd2, SAMP_HALF - 1);
        send_sample(3'd2, -SAMP_HALF - 1);
        send_sample(3'd4, SAMP_MAX);
        drain_filter();

        // Every tap at its rail, pushing hard positive: drive clipping at the positive rail.
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        send_sample(3'd5, SAMP_MAX);
        send_sample(3'd5, SAMP_MAX);
        send_sample(3'd5, SAMP_MAX);
        send_sample(3'd5, SAMP_MIN);
        drain_filter();

        // Every tap at the opposite rail; minus two times minus full scale overflows upwards.
        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
        send_sample(3'd6, SAMP_MIN);
        send_sample(3'd6, SAMP_MIN);
        send_sample(3'd6, '0);
        send_sample(3'd6, SAMP_MAX);
        drain_filter();

        // Unity pass-through across channels.
        load_coefs(COEF_UNITY, '0, '0, '0, '0);
        for (int i = 0; i < 6; i++)
            send_sample(pick_chan(), pick_sample());

        // Random phases, each with its own coefficient set; the last one runs calm.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_filter();
            case (phase)
                0: load_coefs(24'sd283115, 24'sd566231, 24'sd283115,
                              -24'sd4794090, 24'sd1731409);            // low-pass
                1: load_coefs(24'sd3355443, -24'sd6710886, 24'sd3355443,
                              -24'sd6543114, 24'sd2684355);            // high-pass
                2: load_coefs(bqdf1_pkg::COEF_BITS'($urandom),
                              bqdf1_pkg::COEF_BITS'($urandom),
                              bqdf1_pkg::COEF_BITS'($urandom),
                              bqdf1_pkg::COEF_BITS'($urandom),
                              bqdf1_pkg::COEF_BITS'($urandom));
                3: load_coefs(pick_rail_coef(), pick_rail_coef(), pick_rail_coef(),
                              pick_rail_coef(), pick_rail_coef());
                default: load_coefs(COEF_UNITY,
                                    bqdf1_pkg::COEF_BITS'($urandom_range(0, 65535)),
                                    -(bqdf1_pkg::COEF_BITS'($urandom_range(0, 65535))),
                                    bqdf1_pkg::COEF_BITS'($urandom_range(0, 65535)),
                                    -(bqdf1_pkg::COEF_BITS'($urandom_range(0, 65535))));
            endcase
            calm = (phase == RANDOM_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // pause mid-phase until the filter has emptied, with the taps untouched
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    drain_filter();
                send_sample(pick_chan(), pick_sample());
            end
        end

        // Wind down: wait for the last results, then a settling wait for strays.
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("biquad_direct_form_one_filter_top_tb: PASS");
        else
            $display("biquad_direct_form_one_filter_top_tb: FAIL");
        $finish;
    end

endmodule
